/* rtl/cidt_pkg.sv */
// Shared constants, codes and transaction types for the CAN ID dispatch table.
package cidt_pkg;

    // Table geometry
    localparam int STD_ENTRIES = 32;
    localparam int EXT_ENTRIES = 16;
    localparam int ID_MAP_SIZE = 2048;

    localparam int MAP_AW    = $clog2(ID_MAP_SIZE);
    localparam int STD_IDX_W = $clog2(STD_ENTRIES);
    localparam int STD_CNT_W = $clog2(STD_ENTRIES + 1);
    localparam int EXT_IDX_W = $clog2(EXT_ENTRIES);
    localparam int EXT_CNT_W = $clog2(EXT_ENTRIES + 1);

    // Field widths
    localparam int ID_W     = 29;
    localparam int BUS_W    = 2;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 5;
    localparam int SLOT_W   = 6;

    // Map entry that holds no slot
    localparam logic [SLOT_W-1:0] MAP_EMPTY = 6'd63;

    // Request kinds
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_RECEIVE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_REGISTERED  = 3'd0;
    localparam logic [STATUS_W-1:0] STS_TABLE_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_OUT_OF_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] STS_DUPLICATE   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_DISPATCH    = 3'd4;
    localparam logic [STATUS_W-1:0] STS_NO_DISPATCH = 3'd5;

    typedef struct packed {
        logic             req_type;
        logic [BUS_W-1:0] bus;
        logic             extended;
        logic [ID_W-1:0]  frame_id;
        logic [ID_W-1:0]  id_mask;
        logic             handler_present;
        logic [TAG_W-1:0] handler_tag;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  entry_index;
        logic                entry_extended;
        logic [TAG_W-1:0]    consumer_tag;
        logic                last;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic exec_commit;
        logic scan_start;
        logic scan_step;
        logic scan_emit;
        logic final_emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_scan;
        logic scan_end;
        logic scan_hit;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

/* rtl/cidt_ctrl.sv */
// Sequencing state machine for the CAN ID dispatch table.
module cidt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  cidt_pkg::sts_t  sts,
    output cidt_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (sts.out_free)
                begin
                    cmd.exec_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_FINAL;
                end
                else if (sts.scan_hit && sts.pend_valid)
                begin
                    // hold until the output register can take the earlier match
                    if (sts.out_free)
                    begin
                        cmd.scan_step = 1'b1;
                        cmd.scan_emit = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.final_emit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/cidt_dpath.sv */
// Tables, scan datapath and result register for the CAN ID dispatch table.
module cidt_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  cidt_pkg::req_t  req,
    input  cidt_pkg::cmd_t  cmd,
    input  logic            rsp_ready,
    output cidt_pkg::sts_t  sts,
    output cidt_pkg::rsp_t  rsp,
    output logic            rsp_valid
);

    // Captured request
    cidt_pkg::req_t item_reg;

    // ID to slot map with registered read
    logic [cidt_pkg::SLOT_W-1:0] map_mem [cidt_pkg::ID_MAP_SIZE];
    logic [cidt_pkg::SLOT_W-1:0] map_q_reg;
    logic [cidt_pkg::MAP_AW-1:0] clr_addr_reg;

    // Standard entry stores
    logic [cidt_pkg::BUS_W-1:0]   std_bus_mem  [cidt_pkg::STD_ENTRIES];
    logic [cidt_pkg::TAG_W:0]     std_cons_mem [cidt_pkg::STD_ENTRIES];
    logic [cidt_pkg::STD_CNT_W-1:0] std_cnt_reg;

    // Extended entry stores
    logic [cidt_pkg::ID_W-1:0]    ext_key_mem  [cidt_pkg::EXT_ENTRIES];
    logic [cidt_pkg::ID_W-1:0]    ext_mask_mem [cidt_pkg::EXT_ENTRIES];
    logic [cidt_pkg::BUS_W-1:0]   ext_bus_mem  [cidt_pkg::EXT_ENTRIES];
    logic [cidt_pkg::TAG_W:0]     ext_cons_mem [cidt_pkg::EXT_ENTRIES];
    logic [cidt_pkg::EXT_CNT_W-1:0] ext_cnt_reg;

    // Scan position and the match held back until the next one is known
    logic [cidt_pkg::EXT_CNT_W-1:0] scan_idx_reg;
    logic                           pend_valid_reg;
    logic [cidt_pkg::INDEX_W-1:0]   pend_idx_reg;
    logic [cidt_pkg::TAG_W-1:0]     pend_tag_reg;

    cidt_pkg::rsp_t rsp_reg;
    logic           rsp_valid_reg;

    logic [cidt_pkg::EXT_IDX_W-1:0] ext_i;
    logic [cidt_pkg::STD_IDX_W-1:0] std_slot;
    logic [cidt_pkg::STD_IDX_W-1:0] std_wr_idx;
    logic [cidt_pkg::EXT_IDX_W-1:0] ext_wr_idx;
    logic                           std_full;
    logic                           ext_full;
    logic                           id_oor;
    logic                           std_wr;
    logic                           ext_wr;
    logic                           scan_hit;
    logic                           out_free;
    cidt_pkg::rsp_t                 exec_rsp;
    cidt_pkg::rsp_t                 final_rsp;

    assign ext_i      = scan_idx_reg[cidt_pkg::EXT_IDX_W-1:0];
    assign std_slot   = map_q_reg[cidt_pkg::STD_IDX_W-1:0];
    assign std_wr_idx = std_cnt_reg[cidt_pkg::STD_IDX_W-1:0];
    assign ext_wr_idx = ext_cnt_reg[cidt_pkg::EXT_IDX_W-1:0];
    assign std_full   = std_cnt_reg >= cidt_pkg::STD_CNT_W'(cidt_pkg::STD_ENTRIES);
    assign ext_full   = ext_cnt_reg >= cidt_pkg::EXT_CNT_W'(cidt_pkg::EXT_ENTRIES);
    assign id_oor     = item_reg.frame_id >= cidt_pkg::ID_W'(cidt_pkg::ID_MAP_SIZE);
    assign out_free   = !rsp_valid_reg || rsp_ready;

    assign scan_hit = (ext_bus_mem[ext_i] == item_reg.bus)
                   && ((item_reg.frame_id & ext_mask_mem[ext_i])
                       == (ext_key_mem[ext_i] & ext_mask_mem[ext_i]))
                   && ext_cons_mem[ext_i][cidt_pkg::TAG_W];

    // Single-result outcome for registrations and standard frames
    always_comb
    begin
        exec_rsp      = '0;
        exec_rsp.last = 1'b1;
        std_wr        = 1'b0;
        ext_wr        = 1'b0;
        if (item_reg.req_type == cidt_pkg::REQ_REGISTER)
        begin
            if (!item_reg.extended)
            begin
                priority if (std_full)
                begin
                    exec_rsp.status = cidt_pkg::STS_TABLE_FULL;
                end
                else if (id_oor)
                begin
                    exec_rsp.status = cidt_pkg::STS_OUT_OF_RANGE;
                end
                else if (map_q_reg != cidt_pkg::MAP_EMPTY)
                begin
                    exec_rsp.status = cidt_pkg::STS_DUPLICATE;
                end
                else
                begin
                    std_wr               = 1'b1;
                    exec_rsp.status      = cidt_pkg::STS_REGISTERED;
                    exec_rsp.entry_index = cidt_pkg::INDEX_W'(std_cnt_reg);
                end
            end
            else
            begin
                exec_rsp.entry_extended = 1'b1;
                if (ext_full)
                begin
                    exec_rsp.status = cidt_pkg::STS_TABLE_FULL;
                end
                else
                begin
                    ext_wr               = 1'b1;
                    exec_rsp.status      = cidt_pkg::STS_REGISTERED;
                    exec_rsp.entry_index = cidt_pkg::INDEX_W'(ext_cnt_reg);
                end
            end
        end
        else
        begin
            if (!id_oor
                && (map_q_reg != cidt_pkg::MAP_EMPTY)
                && (map_q_reg < cidt_pkg::SLOT_W'(cidt_pkg::STD_ENTRIES))
                && (std_bus_mem[std_slot] == item_reg.bus)
                && std_cons_mem[std_slot][cidt_pkg::TAG_W])
            begin
                exec_rsp.status       = cidt_pkg::STS_DISPATCH;
                exec_rsp.entry_index  = cidt_pkg::INDEX_W'(map_q_reg);
                exec_rsp.consumer_tag = std_cons_mem[std_slot][cidt_pkg::TAG_W-1:0];
            end
            else
            begin
                exec_rsp.status = cidt_pkg::STS_NO_DISPATCH;
            end
        end
    end

    // Closing result of an extended scan
    always_comb
    begin
        final_rsp      = '0;
        final_rsp.last = 1'b1;
        if (pend_valid_reg)
        begin
            final_rsp.status         = cidt_pkg::STS_DISPATCH;
            final_rsp.entry_index    = pend_idx_reg;
            final_rsp.entry_extended = 1'b1;
            final_rsp.consumer_tag   = pend_tag_reg;
        end
        else
        begin
            final_rsp.status = cidt_pkg::STS_NO_DISPATCH;
        end
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            map_mem[clr_addr_reg] <= cidt_pkg::MAP_EMPTY;
        end
        else if (cmd.exec_commit && std_wr)
        begin
            map_mem[item_reg.frame_id[cidt_pkg::MAP_AW-1:0]] <=
                cidt_pkg::SLOT_W'(std_cnt_reg);
        end
        if (cmd.capture)
        begin
            map_q_reg <= map_mem[req.frame_id[cidt_pkg::MAP_AW-1:0]];
        end
    end

    // Entry stores and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.exec_commit && std_wr)
        begin
            std_bus_mem[std_wr_idx]  <= item_reg.bus;
            std_cons_mem[std_wr_idx] <= {item_reg.handler_present, item_reg.handler_tag};
        end
        if (cmd.exec_commit && ext_wr)
        begin
            ext_key_mem[ext_wr_idx]  <= item_reg.frame_id;
            ext_mask_mem[ext_wr_idx] <= item_reg.id_mask;
            ext_bus_mem[ext_wr_idx]  <= item_reg.bus;
            ext_cons_mem[ext_wr_idx] <= {item_reg.handler_present, item_reg.handler_tag};
        end
        if (cmd.scan_step && scan_hit)
        begin
            pend_idx_reg <= cidt_pkg::INDEX_W'(scan_idx_reg);
            pend_tag_reg <= ext_cons_mem[ext_i][cidt_pkg::TAG_W-1:0];
        end
        priority if (cmd.exec_commit)
        begin
            rsp_reg <= exec_rsp;
        end
        else if (cmd.scan_emit)
        begin
            rsp_reg <= '{status:         cidt_pkg::STS_DISPATCH,
                         entry_index:    pend_idx_reg,
                         entry_extended: 1'b1,
                         consumer_tag:   pend_tag_reg,
                         last:           1'b0};
        end
        else if (cmd.final_emit)
        begin
            rsp_reg <= final_rsp;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            std_cnt_reg    <= '0;
            ext_cnt_reg    <= '0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + cidt_pkg::MAP_AW'(1);
            end
            if (cmd.exec_commit && std_wr)
            begin
                std_cnt_reg <= std_cnt_reg + cidt_pkg::STD_CNT_W'(1);
            end
            if (cmd.exec_commit && ext_wr)
            begin
                ext_cnt_reg <= ext_cnt_reg + cidt_pkg::EXT_CNT_W'(1);
            end
            priority if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + cidt_pkg::EXT_CNT_W'(1);
                if (scan_hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (cmd.exec_commit || cmd.scan_emit || cmd.final_emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.clr_done   = clr_addr_reg == cidt_pkg::MAP_AW'(cidt_pkg::ID_MAP_SIZE - 1);
        sts.is_scan    = (item_reg.req_type == cidt_pkg::REQ_RECEIVE) && item_reg.extended;
        sts.scan_end   = scan_idx_reg >= ext_cnt_reg;
        sts.scan_hit   = scan_hit;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/can_id_dispatch_table.sv */
// Top level of the CAN ID dispatch table: controller plus datapath.
//
// CAN receive dispatch table. A register transaction adds a standard entry
// (looked up through a direct 2048-entry ID-to-slot map, 32 slots) or an
// extended entry with a compare mask (16 slots); each gives one result.
// A receive transaction for a standard ID gives one dispatch or no-dispatch
// result; one for an extended ID walks the extended entries in registration
// order, one entry per clock unless a held match waits for the output
// register, and gives a result for every masked match on the same bus that
// has a handler, or a single no-dispatch result. The last result of a
// transaction carries last. After reset the block clears the ID map one
// entry per clock; req_ready first rises once the whole map is clear.
// Thereafter one transaction is handled at a time: a register or standard
// receive result is loaded from the execute state, an extended receive
// scans and then loads its last result from the final state. Each match
// is held back one step so that last can be set on the final one. A loaded
// result waits in an output register, so the next transaction may be
// accepted while it is still pending; back-pressure on rsp_ready stalls the
// controller only when it has a further result to load while the output
// register is still full.
module can_id_dispatch_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  cidt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output cidt_pkg::rsp_t  rsp
);

    cidt_pkg::cmd_t cmd;
    cidt_pkg::sts_t sts;

    // Sequence the clearing pass, execution and the extended scan
    cidt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the tables, evaluate matches and drive the result register
    cidt_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

endmodule

/* tb/tb_can_id_dispatch_table.sv */
// Self-checking testbench for the CAN ID dispatch table: directed and random traffic.
module tb_can_id_dispatch_table;
    import cidt_pkg::*;

    // Every extended entry that gets into the table is made to match this
    // identifier on this bus. That way a receive of it can fan out to all
    // sixteen entries once the table has filled.
    localparam logic [ID_W-1:0]  HUB_ID  = '1;
    localparam logic [BUS_W-1:0] HUB_BUS = 2'd3;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_MATCHES     = 16;
    localparam int REPORT_LIMIT    = 10;
    // Allow time after the last drain for the longest extended scan.
    localparam int SETTLE_CYCLES   = 40;
    // Worst case: a full map clear, then about 320 transactions. An extended
    // receive can fan out to 16 results, and each result can wait out a long stall.
    localparam int TIMEOUT_CYCLES  = 1_000_000;

    // Reference of the table contents, plus the store of results not yet seen.
    class dispatch_scoreboard;
        logic [SLOT_W-1:0] slot_of      [ID_MAP_SIZE];
        logic [BUS_W-1:0]  std_bus      [STD_ENTRIES];
        logic [TAG_W:0]    std_consumer [STD_ENTRIES];  // top bit: handler present
        int                std_used;
        logic [ID_W-1:0]   ext_key      [EXT_ENTRIES];
        logic [ID_W-1:0]   ext_mask     [EXT_ENTRIES];
        logic [BUS_W-1:0]  ext_bus      [EXT_ENTRIES];
        logic [TAG_W:0]    ext_consumer [EXT_ENTRIES];
        int                ext_used;
        rsp_t              awaited [$];
        int                items_seen;
        int                results_seen;
        int                dispatches_seen;
        int                rejections_seen;
        int                widest_fanout;
        int                failures;

        function new();
            foreach (slot_of[i])
                slot_of[i] = MAP_EMPTY;
            std_used = 0;
            ext_used = 0;
            items_seen = 0;
            results_seen = 0;
            dispatches_seen = 0;
            rejections_seen = 0;
            widest_fanout = 0;
            failures = 0;
        endfunction

        function rsp_t result_of(logic [STATUS_W-1:0] st, int idx, logic ext,
                                 logic [TAG_W-1:0] tag);
            rsp_t r;
            r.status         = st;
            r.entry_index    = idx[INDEX_W-1:0];
            r.entry_extended = ext;
            r.consumer_tag   = tag;
            r.last           = 1'b0;
            return r;
        endfunction

        // Update the table for an accepted transaction and queue its results.
        function void note_request(req_t q);
            rsp_t burst [$];
            int   slot;
            items_seen++;
            if (q.req_type == REQ_REGISTER)
            begin
                if (!q.extended)
                begin
                    // Check order: full table, then range, then identifier already mapped
                    if (std_used >= STD_ENTRIES)
                        burst.push_back(result_of(STS_TABLE_FULL, 0, 1'b0, '0));
                    else if (q.frame_id >= ID_MAP_SIZE)
                        burst.push_back(result_of(STS_OUT_OF_RANGE, 0, 1'b0, '0));
                    else if (slot_of[q.frame_id[MAP_AW-1:0]] != MAP_EMPTY)
                        burst.push_back(result_of(STS_DUPLICATE, 0, 1'b0, '0));
                    else
                    begin
                        std_bus[std_used]      = q.bus;
                        std_consumer[std_used] = {q.handler_present, q.handler_tag};
                        slot_of[q.frame_id[MAP_AW-1:0]] = SLOT_W'(std_used);
                        burst.push_back(result_of(STS_REGISTERED, std_used, 1'b0, '0));
                        std_used++;
                    end
                end
                else if (ext_used >= EXT_ENTRIES)
                    burst.push_back(result_of(STS_TABLE_FULL, 0, 1'b1, '0));
                else
                begin
                    // Duplicate extended keys are legal
                    ext_key[ext_used]      = q.frame_id;
                    ext_mask[ext_used]     = q.id_mask;
                    ext_bus[ext_used]      = q.bus;
                    ext_consumer[ext_used] = {q.handler_present, q.handler_tag};
                    burst.push_back(result_of(STS_REGISTERED, ext_used, 1'b1, '0));
                    ext_used++;
                end
                if (burst[0].status != STS_REGISTERED)
                    rejections_seen++;
            end
            else if (!q.extended)
            begin
                // Compare the full 29-bit identifier, so an alias above the map never hits
                if (q.frame_id < ID_MAP_SIZE)
                begin
                    slot = int'(slot_of[q.frame_id[MAP_AW-1:0]]);
                    if (slot < STD_ENTRIES && std_bus[slot] == q.bus &&
                        std_consumer[slot][TAG_W])
                        burst.push_back(result_of(STS_DISPATCH, slot, 1'b0,
                                                  std_consumer[slot][TAG_W-1:0]));
                end
            end
            else
            begin
                // Scan in registration order, reporting at most sixteen matches
                for (int i = 0; i < ext_used && burst.size() < MAX_MATCHES; i++)
                    if (ext_bus[i] == q.bus &&
                        (q.frame_id & ext_mask[i]) == (ext_key[i] & ext_mask[i]) &&
                        ext_consumer[i][TAG_W])
                        burst.push_back(result_of(STS_DISPATCH, i, 1'b1,
                                                  ext_consumer[i][TAG_W-1:0]));
            end
            if (burst.size() == 0)
                burst.push_back(result_of(STS_NO_DISPATCH, 0, 1'b0, '0));
            else if (burst[0].status == STS_DISPATCH)
                dispatches_seen += burst.size();
            burst[burst.size() - 1].last = 1'b1;
            if (burst.size() > widest_fanout)
                widest_fanout = burst.size();
            foreach (burst[i])
                awaited.push_back(burst[i]);
        endfunction

        // Compare one delivered result against the oldest one still awaited.
        function void check_result(rsp_t got);
            rsp_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: status=%0d index=%0d ext=%0b tag=%h last=%0b",
                             got.status, got.entry_index, got.entry_extended,
                             got.consumer_tag, got.last);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.entry_index !== want.entry_index ||
                got.entry_extended !== want.entry_extended ||
                got.consumer_tag !== want.consumer_tag || got.last !== want.last)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result mismatch: expected status=%0d index=%0d ext=%0b tag=%h ",
                             want.status, want.entry_index, want.entry_extended,
                             want.consumer_tag,
                             "last=%0b, got status=%0d index=%0d ext=%0b tag=%h last=%0b",
                             want.last, got.status, got.entry_index,
                             got.entry_extended, got.consumer_tag, got.last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_t               rsp;

    dispatch_scoreboard sb;
    int                 send_idle_pct;
    int                 rsp_stall_pct;
    // Standard identifiers that registration placed in a free slot, with
    // their buses. Used to aim lookups and duplicates at live entries.
    logic [ID_W-1:0]    known_ids   [$];
    logic [BUS_W-1:0]   known_buses [$];

    can_id_dispatch_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall at random at the current rate. Check every result on
    // the edge that accepts it.
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);
    end

    function automatic req_t make_req(logic rt, logic [BUS_W-1:0] bus, logic ext,
                                      logic [ID_W-1:0] id, logic [ID_W-1:0] mask,
                                      logic hp, logic [TAG_W-1:0] tag);
        req_t r;
        r.req_type        = rt;
        r.bus             = bus;
        r.extended        = ext;
        r.frame_id        = id;
        r.id_mask         = mask;
        r.handler_present = hp;
        r.handler_tag     = tag;
        return r;
    endfunction

    // Offer one transaction, idling first at the current rate. Hold valid
    // and payload until the handshake, then pass the accepted item to the
    // scoreboard.
    task automatic send_request(input req_t item);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (item.req_type == REQ_REGISTER && !item.extended && item.frame_id < ID_MAP_SIZE &&
            sb.std_used < STD_ENTRIES && sb.slot_of[item.frame_id[MAP_AW-1:0]] == MAP_EMPTY)
        begin
            known_ids.push_back(item.frame_id);
            known_buses.push_back(item.bus);
        end
        sb.note_request(item);
    endtask

    // Drop valid and hold off until every awaited result has been delivered.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        req_t item;
        int   pick;
        int   k;
        int   j;
        sb = new();
        send_idle_pct = 0;
        rsp_stall_pct <= 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling. Lookups come first, while both tables are empty.
        send_request(make_req(REQ_RECEIVE, 2'd0, 1'b0, '0, '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, HUB_BUS, 1'b1, HUB_ID, '0, 1'b0, '0));
        // Standard registration: both ends of the map, range limit, duplicate, no handler
        send_request(make_req(REQ_REGISTER, 2'd0, 1'b0, '0, HUB_ID, 1'b1, 16'hFFFF));
        send_request(make_req(REQ_REGISTER, 2'd3, 1'b0, ID_W'(ID_MAP_SIZE - 1), '0, 1'b1, '0));
        send_request(make_req(REQ_REGISTER, 2'd1, 1'b0, ID_W'(ID_MAP_SIZE), '0, 1'b1, '0));
        send_request(make_req(REQ_REGISTER, 2'd2, 1'b0, HUB_ID, '0, 1'b1, 16'h00FF));
        send_request(make_req(REQ_REGISTER, 2'd2, 1'b0, '0, '0, 1'b1, 16'h1111));
        send_request(make_req(REQ_REGISTER, 2'd1, 1'b0, 29'd5, '0, 1'b0, 16'h1234));
        // Standard lookups: hits, bus mismatch, missing handler, no truncation above the map
        send_request(make_req(REQ_RECEIVE, 2'd0, 1'b0, '0, '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, 2'd3, 1'b0, ID_W'(ID_MAP_SIZE - 1), '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, 2'd2, 1'b0, ID_W'(ID_MAP_SIZE - 1), '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, 2'd1, 1'b0, 29'd5, '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, 2'd0, 1'b0, ID_W'(ID_MAP_SIZE), '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, 2'd0, 1'b0, 29'h1FFF_F800, '0, 1'b0, '0));
        // Extended: exact key, catch-all mask, and a duplicate key
        send_request(make_req(REQ_REGISTER, HUB_BUS, 1'b1, HUB_ID, HUB_ID, 1'b1, 16'hFFFF));
        send_request(make_req(REQ_REGISTER, HUB_BUS, 1'b1, '0, '0, 1'b1, '0));
        send_request(make_req(REQ_REGISTER, HUB_BUS, 1'b1, HUB_ID, HUB_ID, 1'b1, 16'h5A5A));
        send_request(make_req(REQ_RECEIVE, HUB_BUS, 1'b1, HUB_ID, '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, HUB_BUS, 1'b1, '0, '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, 2'd1, 1'b1, HUB_ID, '0, 1'b0, '0));
        send_request(make_req(REQ_RECEIVE, 2'd2, 1'b1, HUB_ID, '0, 1'b0, '0));
        drain_results();

        // Random part in three pacing phases. Drain fully between phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 77 : 0;
            rsp_stall_pct <= (phase == 0) ? 77 : (phase == 1) ? 37 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Start from noise in every field, then shape the fields that matter
                item.bus             = BUS_W'($urandom);
                item.frame_id        = ID_W'($urandom);
                item.id_mask         = ID_W'($urandom);
                item.handler_present = ($urandom_range(0, 3) != 0);
                item.handler_tag     = TAG_W'($urandom);
                pick = $urandom_range(0, 99);
                k    = $urandom_range(0, 99);
                item.req_type = (pick < 40) ? REQ_REGISTER : REQ_RECEIVE;
                item.extended = (pick >= 20 && pick < 40) || pick >= 70;
                if (pick < 20)
                begin
                    // Standard registration: mostly fresh ids, some repeats, some out of range
                    if (k < 10 && known_ids.size() > 0)
                        item.frame_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
                    else if (k < 15)
                        item.frame_id = ID_W'(ID_MAP_SIZE + $urandom_range(0, 3));
                    else if (k < 20)
                        item.frame_id = item.frame_id | ID_W'(ID_MAP_SIZE);
                    else
                        item.frame_id = ID_W'($urandom_range(0, ID_MAP_SIZE - 1));
                end
                else if (pick < 40)
                begin
                    // Extended registration: keep live entries matching the hub id.
                    // Once the table is full, leave the fields as raw noise.
                    if (sb.ext_used < EXT_ENTRIES)
                    begin
                        if (k < 25)
                            item.id_mask = '0;
                        else if (k < 50)
                            item.id_mask = '1;
                        item.frame_id        = (HUB_ID & item.id_mask) |
                                               (item.frame_id & ~item.id_mask);
                        item.bus             = HUB_BUS;
                        item.handler_present = 1'b1;
                    end
                end
                else if (pick < 70)
                begin
                    // Standard lookup: mostly live entries, then aliases above the map
                    if (k < 50 && known_ids.size() > 0)
                    begin
                        j = $urandom_range(0, known_ids.size() - 1);
                        item.frame_id = known_ids[j];
                        if ($urandom_range(0, 9) < 7)
                            item.bus = known_buses[j];
                    end
                    else if (k < 70)
                        item.frame_id = ID_W'($urandom_range(0, ID_MAP_SIZE - 1));
                    else if (k < 85)
                    begin
                        item.frame_id = item.frame_id | ID_W'(ID_MAP_SIZE);
                        if (known_ids.size() > 0)
                            item.frame_id[MAP_AW-1:0] =
                                known_ids[$urandom_range(0, known_ids.size() - 1)][MAP_AW-1:0];
                    end
                end
                else
                begin
                    // Extended lookup: the hub id fans out widest. Near misses
                    // of a stored key hit subsets of the table.
                    if (k < 30)
                        item.frame_id = HUB_ID;
                    else if (k < 70 && sb.ext_used > 0)
                        item.frame_id = sb.ext_key[$urandom_range(0, sb.ext_used - 1)] ^
                                        ID_W'($urandom & $urandom & $urandom);
                    if ($urandom_range(0, 9) < 7)
                        item.bus = HUB_BUS;
                end
                send_request(item);
            end
            drain_results();
        end

        // Allow for any late or extra result before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d transactions and %0d results: %0d dispatches, %0d rejections.",
                 sb.items_seen, sb.results_seen, sb.dispatches_seen, sb.rejections_seen);
        $display("Tables ended with %0d standard and %0d extended entries; widest fan-out %0d.",
                 sb.std_used, sb.ext_used, sb.widest_fanout);
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: end the run if anything hangs
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/cidt_pkg.sv
rtl/cidt_ctrl.sv
rtl/cidt_dpath.sv
rtl/can_id_dispatch_table.sv
tb/tb_can_id_dispatch_table.sv
